// File: rtl/mbd_pkg.sv
// shared types and constants for the multi-button debounce block
// no dependencies; used by every module of the block
package mbd_pkg;

  // widest button count the block supports
  localparam int MAX_BUTTONS = 8;
  localparam int NUM_BUTTONS_DEFAULT = 8;

  // history values
  localparam logic [7:0] HISTORY_RESET    = 8'h03;
  localparam logic [7:0] HISTORY_PRESSED  = 8'h00;
  localparam logic [7:0] HISTORY_RELEASED = 8'hff;

  // register reset values
  localparam logic [15:0] LONG_MS_RESET     = 16'd5000;
  localparam logic [2:0]  LONG_BUTTON_RESET = 3'd1;

  // register indexes on the configuration port
  localparam logic [1:0] REG_INVERT_MASK       = 2'd0;
  localparam logic [1:0] REG_LONG_PRESS_MS     = 2'd1;
  localparam logic [1:0] REG_LONG_PRESS_BUTTON = 2'd2;

  // what one lane reports for the current tick
  typedef struct packed {
    logic press;
    logic release_evt;
    logic all_ones;
  } lane_evt_t;

  // one result item
  typedef struct packed {
    logic [7:0] press_mask;
    logic [7:0] release_mask;
    logic       long_release;
    logic       all_released;
  } result_t;

endpackage

// File: rtl/multi_button_debounce_long_press.sv
// top level of the multi-button debounce with long-press detection
// depends on mbd_pkg, mbd_lane and mbd_merge
//
//   channel   signals                                   direction  role
//   input     in_valid/in_ready, button_levels, now_ms  in         one scan tick
//   output    out_valid/out_ready, masks and flags      out        one result per tick
//   config    cfg_valid/cfg_ready, cfg_index, cfg_data  in         register writes
//
// every lane updates in the cycle of the input transfer; the result sits in
// an output register from the next cycle, so a tick can be taken every cycle unless the output stalls
// a new tick is taken while the output register is empty or being drained
// a stalled output holds its result and stops further input transfers
// synchronous reset restores histories to 0x03, all buttons released,
// and the registers to their reset values; config is always ready
module multi_button_debounce_long_press #(
  parameter int NUM_BUTTONS = mbd_pkg::NUM_BUTTONS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  button_levels,
  input  logic [31:0] now_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  press_mask,
  output logic [7:0]  release_mask,
  output logic        long_release,
  output logic        all_released,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [7:0]  invert_mask;
  logic [15:0] long_press_ms;
  logic [2:0]  long_press_button;
  logic        advance;
  logic [7:0]  levels;

  mbd_pkg::lane_evt_t [mbd_pkg::MAX_BUTTONS-1:0] evts;
  mbd_pkg::result_t                              result;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign advance   = in_valid && in_ready;
  assign levels    = button_levels ^ invert_mask;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      invert_mask       <= 8'd0;
      long_press_ms     <= mbd_pkg::LONG_MS_RESET;
      long_press_button <= mbd_pkg::LONG_BUTTON_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mbd_pkg::REG_INVERT_MASK:       invert_mask       <= cfg_data[7:0];
        mbd_pkg::REG_LONG_PRESS_MS:     long_press_ms     <= cfg_data;
        mbd_pkg::REG_LONG_PRESS_BUTTON: long_press_button <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // one lane per button, unused lanes report nothing
  for (genvar b = 0; b < mbd_pkg::MAX_BUTTONS; b++) begin : g_lane
    if (b < NUM_BUTTONS) begin : g_used
      mbd_lane u_lane (
        .clk     (clk),
        .rst     (rst),
        .advance (advance),
        .level   (levels[b]),
        .evt     (evts[b])
      );
    end else begin : g_unused
      assign evts[b] = '0;
    end
  end

  mbd_merge #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_merge (
    .clk               (clk),
    .rst               (rst),
    .advance           (advance),
    .evts              (evts),
    .now_ms            (now_ms),
    .long_press_ms     (long_press_ms),
    .long_press_button (long_press_button),
    .result            (result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      press_mask   <= result.press_mask;
      release_mask <= result.release_mask;
      long_release <= result.long_release;
      all_released <= result.all_released;
    end
  end

  // an input transfer always leaves a result waiting
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("input transfer without a result");

  // a button cannot press and release in one tick
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((press_mask & release_mask) == 8'd0))
    else $error("press and release on the same button");

  // all histories at all ones rule out any press
  a_released_no_press: assert property (@(posedge clk) disable iff (rst)
    (out_valid && all_released) |-> (press_mask == 8'd0))
    else $error("press reported while all released");

endmodule

// File: rtl/mbd_lane.sv
// one debounce lane: 8-bit shift history and debounced pressed flag
// depends on mbd_pkg
module mbd_lane (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  logic               level,
  output mbd_pkg::lane_evt_t evt
);

  logic [7:0] history;
  logic       pressed;
  logic [7:0] history_next;

  // new history with the current level as low bit
  assign history_next    = {history[6:0], level};
  assign evt.press       = (history_next == mbd_pkg::HISTORY_PRESSED) && !pressed;
  assign evt.release_evt = (history_next == mbd_pkg::HISTORY_RELEASED) && pressed;
  assign evt.all_ones    = (history_next == mbd_pkg::HISTORY_RELEASED);

  // state update on each accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      history <= mbd_pkg::HISTORY_RESET;
      pressed <= 1'b0;
    end else if (advance) begin
      history <= history_next;
      if (evt.press) begin
        pressed <= 1'b1;
      end else if (evt.release_evt) begin
        pressed <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/mbd_merge.sv
// merging stage: combines lane events into masks and judges long releases
// depends on mbd_pkg; holds the press timestamp of the long-press button
module mbd_merge #(
  parameter int NUM_BUTTONS = mbd_pkg::NUM_BUTTONS_DEFAULT
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          advance,
  input  mbd_pkg::lane_evt_t [mbd_pkg::MAX_BUTTONS-1:0] evts,
  input  logic [31:0]                                   now_ms,
  input  logic [15:0]                                   long_press_ms,
  input  logic [2:0]                                    long_press_button,
  output mbd_pkg::result_t                              result
);

  logic [31:0] press_time;
  logic [31:0] hold;
  logic        long_ok;
  logic        long_hit;

  // hold measured modulo 2^32 against the unsigned threshold
  assign hold     = now_ms - press_time;
  assign long_ok  = hold >= {16'd0, long_press_ms};
  assign long_hit = evts[long_press_button].release_evt && long_ok;

  // combine lanes; lanes beyond the button count report nothing
  always_comb begin
    result.all_released = 1'b1;
    for (int b = 0; b < mbd_pkg::MAX_BUTTONS; b++) begin
      result.press_mask[b]   = evts[b].press;
      result.release_mask[b] = evts[b].release_evt &&
                               !(long_hit && (long_press_button == 3'(b)));
      if (b < NUM_BUTTONS) begin
        result.all_released = result.all_released & evts[b].all_ones;
      end
    end
    result.long_release = long_hit;
  end

  // timestamp taken when the long-press button turns pressed
  always_ff @(posedge clk) begin
    if (rst) begin
      press_time <= 32'd0;
    end else if (advance && evts[long_press_button].press) begin
      press_time <= now_ms;
    end
  end

endmodule
